@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk and held off during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define KLX_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define KLX_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/klx_pkg.sv @@
// ---------------------------------------------------------------------------
// klx_pkg
// Shared types, codes and helpers of the keyword lexer.
// ---------------------------------------------------------------------------
package klx_pkg;

  // Default text buffer size in characters
  localparam int TEXT_MAX_DEF = 63;

  // Token kinds
  typedef logic [4:0] klx_kind_t;
  localparam klx_kind_t KIND_EOF    = 5'd0;
  localparam klx_kind_t KIND_LET    = 5'd1;
  localparam klx_kind_t KIND_PRINT  = 5'd2;
  localparam klx_kind_t KIND_IF     = 5'd3;
  localparam klx_kind_t KIND_ELSE   = 5'd4;
  localparam klx_kind_t KIND_WHILE  = 5'd5;
  localparam klx_kind_t KIND_IDENT  = 5'd6;
  localparam klx_kind_t KIND_NUMBER = 5'd7;
  localparam klx_kind_t KIND_STRING = 5'd8;
  localparam klx_kind_t KIND_EQ     = 5'd9;
  localparam klx_kind_t KIND_ASSIGN = 5'd13;
  localparam klx_kind_t KIND_PLUS   = 5'd14;
  localparam klx_kind_t KIND_MINUS  = 5'd15;
  localparam klx_kind_t KIND_MUL    = 5'd16;
  localparam klx_kind_t KIND_DIV    = 5'd17;
  localparam klx_kind_t KIND_SEMI   = 5'd18;
  localparam klx_kind_t KIND_LPAREN = 5'd19;
  localparam klx_kind_t KIND_RPAREN = 5'd20;
  localparam klx_kind_t KIND_LBRACE = 5'd21;
  localparam klx_kind_t KIND_RBRACE = 5'd22;
  localparam klx_kind_t KIND_GT     = 5'd23;
  localparam klx_kind_t KIND_LT     = 5'd24;

  // Pending operator codes (first character of a possible pair)
  localparam logic [1:0] PEND_EQ   = 2'd0;
  localparam logic [1:0] PEND_BANG = 2'd1;
  localparam logic [1:0] PEND_LT   = 2'd2;
  localparam logic [1:0] PEND_GT   = 2'd3;

  // Keyword spellings, first character in the top byte
  localparam logic [23:0] KW_LET   = "let";
  localparam logic [39:0] KW_PRINT = "print";
  localparam logic [15:0] KW_IF    = "if";
  localparam logic [31:0] KW_ELSE  = "else";
  localparam logic [39:0] KW_WHILE = "while";

  // Scanner mode
  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_WORD = 3'd1,
    MODE_NUM  = 3'd2,
    MODE_STR  = 3'd3,
    MODE_OP   = 3'd4
  } klx_mode_t;

  // Byte class
  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_SPACE,
    CLS_LETTER,
    CLS_DIGIT,
    CLS_QUOTE,
    CLS_PEND,
    CLS_SINGLE
  } klx_cls_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_RD,
    ST_CHAR,
    ST_TOKEN,
    ST_FRESH,
    ST_EOF
  } klx_state_t;

  // Where to go once a pending token is out
  typedef enum logic [1:0] {
    AFT_NONE,
    AFT_FRESH,
    AFT_EOF
  } klx_after_t;

  // Controller to datapath
  typedef struct packed {
    logic      load_in;
    logic      append;
    logic      begin_text;
    logic      set_mode;
    klx_mode_t mode;
    logic      set_pend;
    logic [1:0] pend;
    logic      idx_clr;
    logic      idx_inc;
    logic      rd_en;
    logic      emit;
    klx_kind_t kind;
    logic      emit_char;
    logic      trunc;
    logic      last;
  } klx_cmd_t;

  // Datapath to controller
  typedef struct packed {
    klx_mode_t  mode;
    klx_cls_t   cls;
    klx_kind_t  single_kind;
    logic [1:0] pend_code;
    logic [1:0] pend;
    logic       byte_eq;
    logic       eoi;
    klx_kind_t  kw_kind;
    logic       len_zero;
    logic       ovf;
    logic       char_last;
    logic       slot_free;
  } klx_sts_t;

  // Token for an operator character that was not followed by '='
  function automatic klx_kind_t lone_op_kind(input logic [1:0] p);
    klx_kind_t k;
    unique case (p)
      PEND_EQ: k = KIND_ASSIGN;
      PEND_LT: k = KIND_LT;
      PEND_GT: k = KIND_GT;
      default: k = KIND_EOF;
    endcase
    return k;
  endfunction

endpackage

@@ design/klx_ctrl.sv @@
// ---------------------------------------------------------------------------
// klx_ctrl
// Sequencer of the lexer: decides per byte, flushes tokens, drives the datapath.
// ---------------------------------------------------------------------------
module klx_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  klx_pkg::klx_sts_t sts,
  output klx_pkg::klx_cmd_t cmd
);

  klx_pkg::klx_state_t state_r, state_nxt;
  klx_pkg::klx_after_t after_r, after_nxt;
  klx_pkg::klx_kind_t  tok_r, tok_nxt;
  logic                tok_trunc_r, tok_trunc_nxt;
  klx_pkg::klx_kind_t  txt_r, txt_nxt;

  logic                flush;
  klx_pkg::klx_after_t flush_after;
  logic                start_text;
  klx_pkg::klx_kind_t  start_kind;

  // State after a finished token
  function automatic klx_pkg::klx_state_t after_state(input klx_pkg::klx_after_t a);
    klx_pkg::klx_state_t s;
    unique case (a)
      klx_pkg::AFT_FRESH: s = klx_pkg::ST_FRESH;
      klx_pkg::AFT_EOF:   s = klx_pkg::ST_EOF;
      default:            s = klx_pkg::ST_IDLE;
    endcase
    return s;
  endfunction

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= klx_pkg::ST_IDLE;
      after_r <= klx_pkg::AFT_NONE;
    end else begin
      state_r <= state_nxt;
      after_r <= after_nxt;
    end
  end

  // Token holding registers
  always_ff @(posedge clk) begin
    tok_r       <= tok_nxt;
    tok_trunc_r <= tok_trunc_nxt;
    txt_r       <= txt_nxt;
  end

  assign in_tready = (state_r == klx_pkg::ST_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    after_nxt     = after_r;
    tok_nxt       = tok_r;
    tok_trunc_nxt = tok_trunc_r;
    txt_nxt       = txt_r;
    cmd           = '0;
    cmd.mode      = klx_pkg::MODE_IDLE;
    flush         = 1'b0;
    flush_after   = klx_pkg::AFT_NONE;
    start_text    = 1'b0;
    start_kind    = klx_pkg::KIND_IDENT;

    unique case (state_r)
      klx_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = klx_pkg::ST_DECIDE;
        end
      end

      klx_pkg::ST_DECIDE: begin
        if (sts.eoi) begin
          flush       = 1'b1;
          flush_after = klx_pkg::AFT_EOF;
        end else begin
          unique case (sts.mode)
            klx_pkg::MODE_WORD: begin
              if (sts.cls == klx_pkg::CLS_LETTER || sts.cls == klx_pkg::CLS_DIGIT) begin
                cmd.append = 1'b1;
                state_nxt  = klx_pkg::ST_IDLE;
              end else begin
                flush       = 1'b1;
                flush_after = klx_pkg::AFT_FRESH;
              end
            end
            klx_pkg::MODE_NUM: begin
              if (sts.cls == klx_pkg::CLS_DIGIT) begin
                cmd.append = 1'b1;
                state_nxt  = klx_pkg::ST_IDLE;
              end else begin
                flush       = 1'b1;
                flush_after = klx_pkg::AFT_FRESH;
              end
            end
            klx_pkg::MODE_STR: begin
              if (sts.cls == klx_pkg::CLS_QUOTE) begin
                flush       = 1'b1;
                flush_after = klx_pkg::AFT_NONE;
              end else begin
                cmd.append = 1'b1;
                state_nxt  = klx_pkg::ST_IDLE;
              end
            end
            klx_pkg::MODE_OP: begin
              if (sts.byte_eq) begin
                // two-character comparison operator
                cmd.set_mode  = 1'b1;
                tok_nxt       = klx_pkg::KIND_EQ + {3'd0, sts.pend};
                tok_trunc_nxt = 1'b0;
                after_nxt     = klx_pkg::AFT_NONE;
                state_nxt     = klx_pkg::ST_TOKEN;
              end else begin
                flush       = 1'b1;
                flush_after = klx_pkg::AFT_FRESH;
              end
            end
            default: state_nxt = klx_pkg::ST_FRESH;
          endcase
        end
      end

      klx_pkg::ST_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = klx_pkg::ST_CHAR;
      end

      klx_pkg::ST_CHAR: begin
        if (sts.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.kind      = txt_r;
          cmd.emit_char = 1'b1;
          cmd.last      = sts.char_last;
          cmd.trunc     = sts.char_last & sts.ovf;
          cmd.idx_inc   = 1'b1;
          state_nxt     = sts.char_last ? after_state(after_r) : klx_pkg::ST_RD;
        end
      end

      klx_pkg::ST_TOKEN: begin
        if (sts.slot_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = tok_r;
          cmd.trunc = tok_trunc_r;
          cmd.last  = 1'b1;
          state_nxt = after_state(after_r);
        end
      end

      klx_pkg::ST_FRESH: begin
        cmd.set_mode = 1'b1;
        state_nxt    = klx_pkg::ST_IDLE;
        unique case (sts.cls)
          klx_pkg::CLS_LETTER: begin
            cmd.begin_text = 1'b1;
            cmd.append     = 1'b1;
            cmd.mode       = klx_pkg::MODE_WORD;
          end
          klx_pkg::CLS_DIGIT: begin
            cmd.begin_text = 1'b1;
            cmd.append     = 1'b1;
            cmd.mode       = klx_pkg::MODE_NUM;
          end
          klx_pkg::CLS_QUOTE: begin
            cmd.begin_text = 1'b1;
            cmd.mode       = klx_pkg::MODE_STR;
          end
          klx_pkg::CLS_PEND: begin
            cmd.set_pend = 1'b1;
            cmd.pend     = sts.pend_code;
            cmd.mode     = klx_pkg::MODE_OP;
          end
          klx_pkg::CLS_SINGLE: begin
            tok_nxt       = sts.single_kind;
            tok_trunc_nxt = 1'b0;
            after_nxt     = klx_pkg::AFT_NONE;
            state_nxt     = klx_pkg::ST_TOKEN;
          end
          default: ;
        endcase
      end

      klx_pkg::ST_EOF: begin
        if (sts.slot_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = klx_pkg::KIND_EOF;
          cmd.last  = 1'b1;
          state_nxt = klx_pkg::ST_IDLE;
        end
      end

      default: state_nxt = klx_pkg::ST_IDLE;
    endcase

    // Flush of the pending token; mode returns to idle
    if (flush) begin
      after_nxt    = flush_after;
      cmd.set_mode = 1'b1;
      cmd.mode     = klx_pkg::MODE_IDLE;
      unique case (sts.mode)
        klx_pkg::MODE_WORD: begin
          if (sts.kw_kind != klx_pkg::KIND_EOF) begin
            tok_nxt       = sts.kw_kind;
            tok_trunc_nxt = 1'b0;
            state_nxt     = klx_pkg::ST_TOKEN;
          end else begin
            start_text = 1'b1;
            start_kind = klx_pkg::KIND_IDENT;
          end
        end
        klx_pkg::MODE_NUM: begin
          start_text = 1'b1;
          start_kind = klx_pkg::KIND_NUMBER;
        end
        klx_pkg::MODE_STR: begin
          start_text = 1'b1;
          start_kind = klx_pkg::KIND_STRING;
        end
        klx_pkg::MODE_OP: begin
          if (sts.pend != klx_pkg::PEND_BANG) begin
            tok_nxt       = klx_pkg::lone_op_kind(sts.pend);
            tok_trunc_nxt = 1'b0;
            state_nxt     = klx_pkg::ST_TOKEN;
          end else begin
            state_nxt = after_state(flush_after);
          end
        end
        default: state_nxt = after_state(flush_after);
      endcase

      // Text token: empty text is one result without a character
      if (start_text) begin
        txt_nxt = start_kind;
        if (sts.len_zero) begin
          tok_nxt       = start_kind;
          tok_trunc_nxt = sts.ovf;
          state_nxt     = klx_pkg::ST_TOKEN;
        end else begin
          cmd.idx_clr = 1'b1;
          state_nxt   = klx_pkg::ST_RD;
        end
      end
    end
  end

endmodule

@@ design/klx_dpath.sv @@
// ---------------------------------------------------------------------------
// klx_dpath
// Lexer datapath: input byte, scanner state, text buffer and result register.
// ---------------------------------------------------------------------------
module klx_dpath #(
  parameter int TEXT_MAX = klx_pkg::TEXT_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         in_byte,
  input  logic               in_eoi,
  input  klx_pkg::klx_cmd_t  cmd,
  output klx_pkg::klx_sts_t  sts,
  input  logic               out_tready,
  output logic               out_tvalid,
  output klx_pkg::klx_kind_t out_kind,
  output logic [7:0]         out_char,
  output logic               out_char_valid,
  output logic               out_trunc,
  output logic               out_last
);

  localparam int LEN_W = $clog2(TEXT_MAX + 1);
  localparam int IDX_W = $clog2(TEXT_MAX);

  logic [7:0]          byte_r;
  logic                eoi_r;
  klx_pkg::klx_mode_t  mode_r, mode_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt, len_base;
  logic                ovf_r, ovf_nxt, ovf_base;
  logic [1:0]          pend_r, pend_nxt;
  logic [7:0]          kw_r [5];
  logic [7:0]          mem [TEXT_MAX];
  logic [7:0]          rd_data_r;
  logic [LEN_W-1:0]    idx_r;
  logic                wr_en;
  logic                kw_wr;

  klx_pkg::klx_cls_t   cls;
  klx_pkg::klx_kind_t  single_kind;
  logic [1:0]          pend_code;
  klx_pkg::klx_kind_t  kw_kind;

  logic                out_valid_r;
  klx_pkg::klx_kind_t  out_kind_r;
  logic [7:0]          out_char_r;
  logic                out_cv_r;
  logic                out_trunc_r;
  logic                out_last_r;
  logic                slot_free;

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      byte_r <= in_byte;
      eoi_r  <= in_eoi;
    end
  end

  // Byte classification
  always_comb begin
    cls         = klx_pkg::CLS_OTHER;
    single_kind = klx_pkg::KIND_EOF;
    pend_code   = klx_pkg::PEND_EQ;
    if (byte_r == 8'h20 || (byte_r >= 8'h09 && byte_r <= 8'h0d)) begin
      cls = klx_pkg::CLS_SPACE;
    end else if ((byte_r >= "a" && byte_r <= "z") || (byte_r >= "A" && byte_r <= "Z")) begin
      cls = klx_pkg::CLS_LETTER;
    end else if (byte_r >= "0" && byte_r <= "9") begin
      cls = klx_pkg::CLS_DIGIT;
    end else if (byte_r == 8'h22) begin
      cls = klx_pkg::CLS_QUOTE;
    end else begin
      unique case (byte_r)
        "=": begin cls = klx_pkg::CLS_PEND; pend_code = klx_pkg::PEND_EQ; end
        "!": begin cls = klx_pkg::CLS_PEND; pend_code = klx_pkg::PEND_BANG; end
        "<": begin cls = klx_pkg::CLS_PEND; pend_code = klx_pkg::PEND_LT; end
        ">": begin cls = klx_pkg::CLS_PEND; pend_code = klx_pkg::PEND_GT; end
        "+": begin cls = klx_pkg::CLS_SINGLE; single_kind = klx_pkg::KIND_PLUS; end
        "-": begin cls = klx_pkg::CLS_SINGLE; single_kind = klx_pkg::KIND_MINUS; end
        "*": begin cls = klx_pkg::CLS_SINGLE; single_kind = klx_pkg::KIND_MUL; end
        "/": begin cls = klx_pkg::CLS_SINGLE; single_kind = klx_pkg::KIND_DIV; end
        ";": begin cls = klx_pkg::CLS_SINGLE; single_kind = klx_pkg::KIND_SEMI; end
        "(": begin cls = klx_pkg::CLS_SINGLE; single_kind = klx_pkg::KIND_LPAREN; end
        ")": begin cls = klx_pkg::CLS_SINGLE; single_kind = klx_pkg::KIND_RPAREN; end
        "{": begin cls = klx_pkg::CLS_SINGLE; single_kind = klx_pkg::KIND_LBRACE; end
        "}": begin cls = klx_pkg::CLS_SINGLE; single_kind = klx_pkg::KIND_RBRACE; end
        default: ;
      endcase
    end
  end

  // Text append; a new token restarts at position zero
  always_comb begin
    len_base = cmd.begin_text ? '0 : len_r;
    ovf_base = cmd.begin_text ? 1'b0 : ovf_r;
    len_nxt  = len_base;
    ovf_nxt  = ovf_base;
    wr_en    = 1'b0;
    kw_wr    = 1'b0;
    if (cmd.append) begin
      if (len_base < LEN_W'(TEXT_MAX)) begin
        wr_en   = 1'b1;
        kw_wr   = (len_base < LEN_W'(5));
        len_nxt = len_base + LEN_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    mode_nxt = cmd.set_mode ? cmd.mode : mode_r;
    pend_nxt = cmd.set_pend ? cmd.pend : pend_r;
  end

  // Scanner state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= klx_pkg::MODE_IDLE;
      len_r  <= '0;
      ovf_r  <= 1'b0;
      pend_r <= klx_pkg::PEND_EQ;
    end else begin
      mode_r <= mode_nxt;
      len_r  <= len_nxt;
      ovf_r  <= ovf_nxt;
      pend_r <= pend_nxt;
    end
  end

  // Text buffer and keyword shadow of the first five characters
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[len_base[IDX_W-1:0]] <= byte_r;
    end
    if (kw_wr) begin
      kw_r[len_base[2:0]] <= byte_r;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[idx_r[IDX_W-1:0]];
    end
  end

  // Emit index
  always_ff @(posedge clk) begin
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + LEN_W'(1);
    end
  end

  // Keyword match; a cut word never matches
  always_comb begin
    kw_kind = klx_pkg::KIND_EOF;
    if (!ovf_r) begin
      if (len_r == LEN_W'(3) && {kw_r[0], kw_r[1], kw_r[2]} == klx_pkg::KW_LET) begin
        kw_kind = klx_pkg::KIND_LET;
      end else if (len_r == LEN_W'(5) &&
                   {kw_r[0], kw_r[1], kw_r[2], kw_r[3], kw_r[4]} == klx_pkg::KW_PRINT) begin
        kw_kind = klx_pkg::KIND_PRINT;
      end else if (len_r == LEN_W'(2) && {kw_r[0], kw_r[1]} == klx_pkg::KW_IF) begin
        kw_kind = klx_pkg::KIND_IF;
      end else if (len_r == LEN_W'(4) &&
                   {kw_r[0], kw_r[1], kw_r[2], kw_r[3]} == klx_pkg::KW_ELSE) begin
        kw_kind = klx_pkg::KIND_ELSE;
      end else if (len_r == LEN_W'(5) &&
                   {kw_r[0], kw_r[1], kw_r[2], kw_r[3], kw_r[4]} == klx_pkg::KW_WHILE) begin
        kw_kind = klx_pkg::KIND_WHILE;
      end
    end
  end

  // Result register
  assign slot_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind_r  <= cmd.kind;
      out_char_r  <= cmd.emit_char ? rd_data_r : 8'd0;
      out_cv_r    <= cmd.emit_char;
      out_trunc_r <= cmd.trunc;
      out_last_r  <= cmd.last;
    end
  end

  assign out_tvalid     = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_char       = out_char_r;
  assign out_char_valid = out_cv_r;
  assign out_trunc      = out_trunc_r;
  assign out_last       = out_last_r;

  // Status to the controller
  always_comb begin
    sts             = '0;
    sts.mode        = mode_r;
    sts.cls         = cls;
    sts.single_kind = single_kind;
    sts.pend_code   = pend_code;
    sts.pend        = pend_r;
    sts.byte_eq     = (byte_r == "=");
    sts.eoi         = eoi_r;
    sts.kw_kind     = kw_kind;
    sts.len_zero    = (len_r == '0);
    sts.ovf         = ovf_r;
    sts.char_last   = ((idx_r + LEN_W'(1)) == len_r);
    sts.slot_free   = slot_free;
  end

endmodule

@@ design/keyword_lexer_top.sv @@
// ---------------------------------------------------------------------------
// keyword_lexer_top
// Byte-stream tokenizer with keyword, number, string and operator tokens.
// ---------------------------------------------------------------------------
// Input channel: one source byte per transfer on in_tdata; in_tlast high marks
// end of input (the byte is then ignored), which flushes any pending token and
// sends an EOF token.
// Output channel: one result per transfer. A token with text is sent as one
// transfer per character, out_tlast on its final character; tokens without
// text are a single transfer with char_valid low.
// Sequence: a byte that only extends the current token goes through the
// decide state back to idle. A flushed text token sends each character as a
// registered text buffer read, then the output load; a token without text
// needs no buffer read. The controller handles one byte at a time, so the
// byte rate is set by the sequencer and the buffer read port.
// Reset: the scanner returns to idle with an empty buffer; no result pending.
// Stall: a result waits in the output register while out_tready is low and
// the sequencer holds; no input is taken until the byte is fully handled.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module keyword_lexer_top #(
  parameter int TEXT_MAX = klx_pkg::TEXT_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_in
  input  logic        in_tlast,   // end_of_input
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] text_char, [8] char_valid, [9] truncated
  output logic [4:0]  out_tuser,  // [4:0] token_kind
  output logic        out_tlast   // last
);

  klx_pkg::klx_cmd_t  cmd;
  klx_pkg::klx_sts_t  sts;
  klx_pkg::klx_kind_t kind;
  logic [7:0]         text_char;
  logic               char_valid;
  logic               truncated;

  klx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  klx_dpath #(
    .TEXT_MAX (TEXT_MAX)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_byte        (in_tdata),
    .in_eoi         (in_tlast),
    .cmd            (cmd),
    .sts            (sts),
    .out_tready     (out_tready),
    .out_tvalid     (out_tvalid),
    .out_kind       (kind),
    .out_char       (text_char),
    .out_char_valid (char_valid),
    .out_trunc      (truncated),
    .out_last       (out_tlast)
  );

  assign out_tdata = {6'd0, truncated, char_valid, text_char};
  assign out_tuser = kind;

  // Checks
  `KLX_ASSERT_NXT(a_one_byte, in_tvalid && in_tready, !in_tready, "byte taken while busy")
  `KLX_ASSERT_IMP(a_trunc_last, out_tvalid && out_tdata[9], out_tlast, "truncated off last")
  `KLX_ASSERT_IMP(a_char_zero, out_tvalid && !out_tdata[8], out_tdata[7:0] == 8'd0,
                  "text char set without char_valid")

endmodule
